### hdl/b58_pkg.sv
// ----------------------------------------------------------------------------
// b58_pkg
// Shared types, constants and the character lookup of the base-58 encoder.
// ----------------------------------------------------------------------------
package b58_pkg;

    localparam int RADIX       = 58;
    localparam int DIGIT_W     = 6;
    localparam int CARRY_W     = 8;
    localparam int VAL_W       = 14;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 20;
    localparam int QEST_W      = 9;
    localparam int RESULT_CAP  = 44;
    localparam int EMIT_W      = 6;

    // floor(2^20 / 58); the estimate is low by at most one.
    localparam logic [RECIP_W-1:0] RECIP    = 15'd18078;
    localparam logic [6:0]         CHAR_ONE = 7'd49;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
        logic       overflow;
    } out_word_t;

    // Maps a digit to its character; the alphabet skips 0, I, O and l.
    function automatic logic [6:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [6:0] dw;
        logic [6:0] code;
        dw = 7'(d);
        if (d < 6'd9)
            code = dw + 7'd49;
        else if (d < 6'd17)
            code = dw + 7'd56;
        else if (d < 6'd22)
            code = dw + 7'd57;
        else if (d < 6'd33)
            code = dw + 7'd58;
        else if (d < 6'd44)
            code = dw + 7'd64;
        else if (d < 6'd58)
            code = dw + 7'd65;
        else
            code = CHAR_ONE;
        return code;
    endfunction

endpackage

### hdl/base58_encoder.sv
// ----------------------------------------------------------------------------
// base58_encoder
// Streaming base-58 encoder: bytes in, most significant first; characters out.
// ----------------------------------------------------------------------------
//  channel  direction  payload     handshake
//  in       input      in_word_t   in_valid / in_stall
//  out      output     out_word_t  out_valid / out_stall
//
// A byte holds in_stall high while it walks the stored digits and appends new
// ones, each digit taking S_MUL and S_FIX in the shared divide-by-58 unit, so
// a new byte is accepted only once the state is back in S_IDLE; a dropped byte
// stalls the input only while S_DONE is passed. After the last byte, each
// character passes S_EMIT_RD, S_EMIT_LD and S_EMIT_WAIT, waiting on out_stall.
// Reset clears all string state; the digit memory is never cleared.
// ----------------------------------------------------------------------------
module base58_encoder
    import b58_pkg::*;
#(
    parameter int MAX_BYTES  = 32,
    parameter int MAX_DIGITS = 44
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    localparam int BW  = $clog2(MAX_BYTES + 1);
    localparam int DW  = $clog2(MAX_DIGITS + 1);
    localparam int AW  = $clog2(MAX_DIGITS);
    localparam int MW  = (BW > DW) ? BW : DW;
    localparam int TW  = ((MW > EMIT_W) ? MW : EMIT_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_FIX,
        S_DONE,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } state_t;

    state_t             state_reg, state_next;
    logic [DW-1:0]      digit_count_reg, digit_count_next;
    logic [BW-1:0]      zero_count_reg, zero_count_next;
    logic               in_zero_reg, in_zero_next;
    logic [BW-1:0]      byte_count_reg, byte_count_next;
    logic               ovf_reg, ovf_next;
    logic               last_reg, last_next;
    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic [DW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [EMIT_W-1:0]  emit_left_reg, emit_left_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;

    logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
    logic [DIGIT_W-1:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;

    logic [VAL_W-1:0]   dm_value;
    logic [CARRY_W-1:0] dm_quot;
    logic [DIGIT_W-1:0] dm_rem;
    logic               walking;
    logic [TW-1:0]      total;

    b58_divmod u_divmod (
        .clk   (clk),
        .value (dm_value),
        .quot  (dm_quot),
        .rem   (dm_rem)
    );

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            digit_mem[idx_reg[AW-1:0]] <= dm_rem;
        end
        rd_data_reg <= digit_mem[rd_addr];
    end

    assign walking  = (idx_reg < digit_count_reg);
    assign total    = TW'(zero_count_reg) + TW'(digit_count_reg);
    assign wr_en    = (state_reg == S_FIX);
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_comb
    begin
        if (walking)
            dm_value = {rd_data_reg, 8'h00} + VAL_W'(carry_reg);
        else
            dm_value = VAL_W'(carry_reg);
    end

    always_comb
    begin
        case (state_reg)
            S_FIX:     rd_addr = AW'(idx_reg + DW'(1));
            S_EMIT_RD: rd_addr = rd_ptr_reg;
            default:   rd_addr = '0;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        digit_count_next = digit_count_reg;
        zero_count_next  = zero_count_reg;
        in_zero_next     = in_zero_reg;
        byte_count_next  = byte_count_reg;
        ovf_next         = ovf_reg;
        last_next        = last_reg;
        carry_next       = carry_reg;
        idx_next         = idx_reg;
        rd_ptr_next      = rd_ptr_reg;
        emit_left_next   = emit_left_reg;
        out_valid_next   = out_valid_reg;
        out_word_next    = out_word_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    last_next = in_word.last_byte;
                    if (byte_count_reg < BW'(MAX_BYTES))
                    begin
                        if (in_zero_reg && (in_word.data_byte == 8'h00))
                            zero_count_next = zero_count_reg + BW'(1);
                        else
                            in_zero_next = 1'b0;
                        carry_next      = in_word.data_byte;
                        idx_next        = '0;
                        byte_count_next = byte_count_reg + BW'(1);
                        state_next      = S_MUL;
                    end
                    else
                    begin
                        ovf_next   = 1'b1;
                        state_next = S_DONE;
                    end
                end
            end

            S_MUL:
            begin
                // Past the stored digits the carry is appended as new digits.
                if (walking)
                    state_next = S_FIX;
                else if (carry_reg == '0)
                    state_next = S_DONE;
                else if (digit_count_reg == DW'(MAX_DIGITS))
                begin
                    ovf_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_FIX;
            end

            S_FIX:
            begin
                carry_next = dm_quot;
                if (idx_reg == digit_count_reg)
                    digit_count_next = digit_count_reg + DW'(1);
                idx_next   = idx_reg + DW'(1);
                state_next = S_MUL;
            end

            S_DONE:
            begin
                if (!last_reg)
                    state_next = S_IDLE;
                else
                begin
                    if (total > TW'(RESULT_CAP))
                    begin
                        emit_left_next = EMIT_W'(RESULT_CAP);
                        ovf_next       = 1'b1;
                    end
                    else
                        emit_left_next = total[EMIT_W-1:0];
                    rd_ptr_next = AW'(digit_count_reg - DW'(1));
                    if (total == '0)
                    begin
                        digit_count_next = '0;
                        zero_count_next  = '0;
                        in_zero_next     = 1'b1;
                        byte_count_next  = '0;
                        ovf_next         = 1'b0;
                        state_next       = S_IDLE;
                    end
                    else
                        state_next = S_EMIT_RD;
                end
            end

            S_EMIT_RD:
            begin
                state_next = S_EMIT_LD;
            end

            S_EMIT_LD:
            begin
                out_valid_next          = 1'b1;
                out_word_next.last_char = (emit_left_reg == EMIT_W'(1));
                out_word_next.overflow  = ovf_reg;
                // The zero prefix is spent first, then digits top down.
                if (zero_count_reg != '0)
                begin
                    out_word_next.char_code = CHAR_ONE;
                    zero_count_next         = zero_count_reg - BW'(1);
                end
                else
                begin
                    out_word_next.char_code = b58_char(rd_data_reg);
                    rd_ptr_next             = rd_ptr_reg - AW'(1);
                end
                emit_left_next = emit_left_reg - EMIT_W'(1);
                state_next     = S_EMIT_WAIT;
            end

            S_EMIT_WAIT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (emit_left_reg == '0)
                    begin
                        digit_count_next = '0;
                        zero_count_next  = '0;
                        in_zero_next     = 1'b1;
                        byte_count_next  = '0;
                        ovf_next         = 1'b0;
                        state_next       = S_IDLE;
                    end
                    else
                        state_next = S_EMIT_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            digit_count_reg <= '0;
            zero_count_reg  <= '0;
            in_zero_reg     <= 1'b1;
            byte_count_reg  <= '0;
            ovf_reg         <= 1'b0;
            last_reg        <= 1'b0;
            carry_reg       <= '0;
            idx_reg         <= '0;
            rd_ptr_reg      <= '0;
            emit_left_reg   <= '0;
            out_valid_reg   <= 1'b0;
            out_word_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            digit_count_reg <= digit_count_next;
            zero_count_reg  <= zero_count_next;
            in_zero_reg     <= in_zero_next;
            byte_count_reg  <= byte_count_next;
            ovf_reg         <= ovf_next;
            last_reg        <= last_next;
            carry_reg       <= carry_next;
            idx_reg         <= idx_next;
            rd_ptr_reg      <= rd_ptr_next;
            emit_left_reg   <= emit_left_next;
            out_valid_reg   <= out_valid_next;
            out_word_reg    <= out_word_next;
        end
    end

endmodule

### hdl/b58_divmod.sv
// ----------------------------------------------------------------------------
// b58_divmod
// Divide and remainder by 58 for values below 2^14, by reciprocal multiply.
// The product is registered; quotient and remainder follow in the next cycle.
// ----------------------------------------------------------------------------
module b58_divmod
    import b58_pkg::*;
(
    input  logic               clk,
    input  logic [VAL_W-1:0]   value,
    output logic [CARRY_W-1:0] quot,
    output logic [DIGIT_W-1:0] rem
);

    logic [VAL_W-1:0]         value_reg;
    logic [VAL_W+RECIP_W-1:0] prod_reg;
    logic [QEST_W-1:0]        q_est;
    logic [VAL_W-1:0]         r_est;

    always_ff @(posedge clk)
    begin
        value_reg <= value;
        prod_reg  <= (VAL_W+RECIP_W)'(value) * (VAL_W+RECIP_W)'(RECIP);
    end

    always_comb
    begin
        q_est = prod_reg[RECIP_SHIFT +: QEST_W];
        r_est = value_reg - VAL_W'(q_est) * VAL_W'(RADIX);
        // The estimate may be one short; a single correction step fixes it.
        if (r_est >= VAL_W'(RADIX))
        begin
            quot = CARRY_W'(q_est + QEST_W'(1));
            rem  = DIGIT_W'(r_est - VAL_W'(RADIX));
        end
        else
        begin
            quot = CARRY_W'(q_est);
            rem  = DIGIT_W'(r_est);
        end
    end

endmodule
